/* hw/rtl/vbi_pkg.sv */
package vbi_pkg;

    // Default grid size in voxels
    localparam int DEF_GRID_X = 64;
    localparam int DEF_GRID_Y = 64;
    localparam int DEF_GRID_Z = 32;

    // Field widths
    localparam int STEP_W = 3;
    localparam int VOX_W  = 8;
    // Signed box coordinate: covers -7 .. 127 + 7
    localparam int COORD_W = 10;
    // Signed box offset: covers -7 .. 7
    localparam int OFS_W = 4;

    // Configuration register indexes
    localparam logic REG_INFLATE = 1'b0;
    localparam logic REG_EXTRA   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0] INFLATE_RST = 3'd2;
    localparam logic [STEP_W-1:0] EXTRA_RST   = 3'd4;

    typedef enum logic [1:0] {
        KIND_MARK  = 2'd0,
        KIND_END   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MARK,
        ST_FLUSH,
        ST_QREAD,
        ST_QDATA
    } t_state;

    // Column request from the box walker
    typedef struct packed {
        logic active;
        logic in_grid;
        logic last;
        logic set_inf;
        logic set_ext;
    } t_col_ctl;

endpackage

/* hw/rtl/voxel_box_inflation.sv */
// Voxel box inflation. Keeps an inflated and an extra-inflated occupancy map
// over a GRID_X x GRID_Y x GRID_Z grid, packed one z-column word per (x, y)
// in a single memory holding both maps side by side. Pulse start with an item
// while busy is low; every item gives exactly one result, shown for one cycle
// with o_result_valid, and the receiver cannot stall it. From the accepting
// edge to the result strobe: an end item, an ignored mark or an out-of-grid
// query pass only the result register; an in-grid query also passes the memory
// read and the data register; an applied mark gives every column of the (2s+1)^2
// box one pipelined read-modify-write through the single write port, s being
// the larger of inflate_steps and extra_steps; a clear item clears one memory
// word per cycle. After reset, busy stays high while the same clearing pass
// empties the memory; configuration writes are taken at any time.
module voxel_box_inflation #(
    parameter int GRID_X = vbi_pkg::DEF_GRID_X,
    parameter int GRID_Y = vbi_pkg::DEF_GRID_Y,
    parameter int GRID_Z = vbi_pkg::DEF_GRID_Z
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_kind,
    input  logic signed [vbi_pkg::VOX_W-1:0] i_vox_x,
    input  logic signed [vbi_pkg::VOX_W-1:0] i_vox_y,
    input  logic signed [vbi_pkg::VOX_W-1:0] i_vox_z,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [vbi_pkg::STEP_W-1:0] i_cfg_data,
    output logic                       o_result_valid,
    output logic                       o_in_grid,
    output logic                       o_inflated_bit,
    output logic                       o_extra_bit,
    output logic                       o_map_done,
    output logic                       o_mark_taken
);

    localparam int XW   = $clog2(GRID_X);
    localparam int YW   = $clog2(GRID_Y);
    localparam int ZW   = $clog2(GRID_Z);
    localparam int COLS = GRID_X * GRID_Y;
    localparam int AW   = $clog2(COLS);
    localparam int DW   = 2 * GRID_Z;
    localparam int CMPW = vbi_pkg::VOX_W + 1;

    // Both maps: extra in the upper half, inflated in the lower half
    logic [DW-1:0] mem [COLS];

    vbi_pkg::t_state r_state;
    vbi_pkg::t_state n_state;

    logic [vbi_pkg::STEP_W-1:0] r_inflate_steps;
    logic [vbi_pkg::STEP_W-1:0] r_extra_steps;
    logic                       r_done;
    logic                       r_clr_item;
    logic [AW-1:0]              r_clr_cnt;
    logic [XW-1:0]              r_cx;
    logic [YW-1:0]              r_cy;
    logic [ZW-1:0]              r_cz;
    logic [GRID_Z-1:0]          r_zmask;
    logic [AW-1:0]              r_q_addr;
    logic                       r_ing;
    logic [DW-1:0]              r_rdata;
    logic                       r_wr_en;
    logic [AW-1:0]              r_wr_addr;
    logic                       r_wr_inf;
    logic                       r_wr_ext;

    logic                       r_res_valid;
    logic                       r_res_ing;
    logic                       r_res_inf;
    logic                       r_res_ext;
    logic                       r_res_done;
    logic                       r_res_taken;

    vbi_pkg::t_kind    kind;
    logic              accept;
    logic              ing;
    logic [GRID_Z+1:0] zwide;
    logic [GRID_Z-1:0] zmask;
    logic [AW-1:0]     in_addr;
    logic              clr_last;
    logic [GRID_Z-1:0] rd_inf;
    logic [GRID_Z-1:0] rd_ext;

    vbi_pkg::t_col_ctl walk_ctl;
    logic [AW-1:0]     walk_addr;

    logic              walk_start;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              res_valid;
    logic              res_ing;
    logic              res_inf;
    logic              res_ext;
    logic              res_done;
    logic              res_taken;

    assign kind   = vbi_pkg::t_kind'(i_kind);
    assign busy   = (r_state != vbi_pkg::ST_IDLE);
    assign accept = start && !busy;

    // Grid check on the incoming voxel
    assign ing = !i_vox_x[vbi_pkg::VOX_W-1]
              && ({1'b0, i_vox_x} < CMPW'(GRID_X))
              && !i_vox_y[vbi_pkg::VOX_W-1]
              && ({1'b0, i_vox_y} < CMPW'(GRID_Y))
              && !i_vox_z[vbi_pkg::VOX_W-1]
              && ({1'b0, i_vox_z} < CMPW'(GRID_Z));

    // Z bits z-1 .. z+1 that lie inside the column
    assign zwide   = (GRID_Z + 2)'(3'b111) << i_vox_z[ZW-1:0];
    assign zmask   = zwide[GRID_Z:1];
    assign in_addr = AW'(i_vox_x[XW-1:0]) * AW'(GRID_Y) + AW'(i_vox_y[YW-1:0]);

    assign clr_last = (r_clr_cnt == AW'(COLS - 1));

    // Split the read word into its two map columns
    assign rd_inf = r_rdata[GRID_Z-1:0];
    assign rd_ext = r_rdata[DW-1:GRID_Z];

    vbi_box_walk #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (walk_start),
        .i_cx            (r_cx),
        .i_cy            (r_cy),
        .i_inflate_steps (r_inflate_steps),
        .i_extra_steps   (r_extra_steps),
        .o_ctl           (walk_ctl),
        .o_addr          (walk_addr)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vbi_pkg::ST_IDLE: begin
                if (accept) begin
                    case (kind)
                        vbi_pkg::KIND_MARK:  n_state = (!r_done && ing) ? vbi_pkg::ST_MARK
                                                                      : vbi_pkg::ST_IDLE;
                        vbi_pkg::KIND_QUERY: n_state = ing ? vbi_pkg::ST_QREAD
                                                           : vbi_pkg::ST_IDLE;
                        vbi_pkg::KIND_CLEAR: n_state = vbi_pkg::ST_CLEAR;
                        default:             n_state = vbi_pkg::ST_IDLE;
                    endcase
                end
            end
            vbi_pkg::ST_CLEAR: if (clr_last) n_state = vbi_pkg::ST_IDLE;
            vbi_pkg::ST_MARK:  if (walk_ctl.last) n_state = vbi_pkg::ST_FLUSH;
            vbi_pkg::ST_FLUSH: n_state = vbi_pkg::ST_IDLE;
            vbi_pkg::ST_QREAD: n_state = vbi_pkg::ST_QDATA;
            vbi_pkg::ST_QDATA: n_state = vbi_pkg::ST_IDLE;
            default:           n_state = vbi_pkg::ST_IDLE;
        endcase
    end

    // Memory control and result fields
    always_comb begin
        walk_start = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_wr_addr;
        mem_wdata  = r_rdata | {(r_wr_ext ? r_zmask : {GRID_Z{1'b0}}),
                                (r_wr_inf ? r_zmask : {GRID_Z{1'b0}})};
        mem_re     = 1'b0;
        mem_raddr  = walk_addr;
        res_valid  = 1'b0;
        res_ing    = r_ing;
        res_inf    = 1'b0;
        res_ext    = 1'b0;
        res_done   = r_done;
        res_taken  = 1'b0;
        case (r_state)
            vbi_pkg::ST_IDLE: begin
                if (accept) begin
                    res_ing = ing;
                    case (kind)
                        vbi_pkg::KIND_MARK: begin
                            walk_start = !r_done && ing;
                            res_valid  = r_done || !ing;
                        end
                        vbi_pkg::KIND_END: begin
                            res_valid = 1'b1;
                            res_done  = 1'b1;
                        end
                        vbi_pkg::KIND_QUERY: res_valid = !ing;
                        default:             res_valid = 1'b0;
                    endcase
                end
            end
            vbi_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = {DW{1'b0}};
                res_valid = clr_last && r_clr_item;
                res_done  = 1'b0;
            end
            vbi_pkg::ST_MARK: begin
                mem_we = r_wr_en;
                mem_re = walk_ctl.in_grid;
            end
            vbi_pkg::ST_FLUSH: begin
                mem_we    = r_wr_en;
                res_valid = 1'b1;
                res_taken = 1'b1;
            end
            vbi_pkg::ST_QREAD: begin
                mem_re    = 1'b1;
                mem_raddr = r_q_addr;
            end
            vbi_pkg::ST_QDATA: begin
                res_valid = 1'b1;
                res_inf   = rd_inf[r_cz];
                res_ext   = rd_ext[r_cz];
            end
            default: res_valid = 1'b0;
        endcase
    end

    // Hold the map memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Control state; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= vbi_pkg::ST_CLEAR;
            r_clr_cnt       <= {AW{1'b0}};
            r_clr_item      <= 1'b0;
            r_done          <= 1'b0;
            r_wr_en         <= 1'b0;
            r_res_valid     <= 1'b0;
            r_inflate_steps <= vbi_pkg::INFLATE_RST;
            r_extra_steps   <= vbi_pkg::EXTRA_RST;
        end else begin
            r_state     <= n_state;
            r_res_valid <= res_valid;
            r_wr_en     <= (r_state == vbi_pkg::ST_MARK) && walk_ctl.in_grid;
            if (i_cfg_we) begin
                if (i_cfg_idx == vbi_pkg::REG_INFLATE) begin
                    r_inflate_steps <= i_cfg_data;
                end else begin
                    r_extra_steps <= i_cfg_data;
                end
            end
            if (r_state == vbi_pkg::ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (accept && kind == vbi_pkg::KIND_END) begin
                r_done <= 1'b1;
            end
            if (accept && kind == vbi_pkg::KIND_CLEAR) begin
                r_done     <= 1'b0;
                r_clr_item <= 1'b1;
                r_clr_cnt  <= {AW{1'b0}};
            end
        end
    end

    // Latch the item and the write-back stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx     <= i_vox_x[XW-1:0];
            r_cy     <= i_vox_y[YW-1:0];
            r_cz     <= i_vox_z[ZW-1:0];
            r_zmask  <= zmask;
            r_q_addr <= in_addr;
            r_ing    <= ing;
        end
        r_wr_addr <= walk_addr;
        r_wr_inf  <= walk_ctl.set_inf;
        r_wr_ext  <= walk_ctl.set_ext;
        if (res_valid) begin
            r_res_ing   <= res_ing;
            r_res_inf   <= res_inf;
            r_res_ext   <= res_ext;
            r_res_done  <= res_done;
            r_res_taken <= res_taken;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_in_grid      = r_res_ing;
    assign o_inflated_bit = r_res_inf;
    assign o_extra_bit    = r_res_ext;
    assign o_map_done     = r_res_done;
    assign o_mark_taken   = r_res_taken;

endmodule

/* hw/rtl/vbi_box_walk.sv */
// Walks the (2s+1) x (2s+1) column box around a mark, s being the larger
// half-width, one column per cycle.
module vbi_box_walk #(
    parameter int GRID_X = vbi_pkg::DEF_GRID_X,
    parameter int GRID_Y = vbi_pkg::DEF_GRID_Y,
    localparam int XW = $clog2(GRID_X),
    localparam int YW = $clog2(GRID_Y),
    localparam int AW = $clog2(GRID_X * GRID_Y)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [XW-1:0]             i_cx,
    input  logic [YW-1:0]             i_cy,
    input  logic [vbi_pkg::STEP_W-1:0] i_inflate_steps,
    input  logic [vbi_pkg::STEP_W-1:0] i_extra_steps,
    output vbi_pkg::t_col_ctl         o_ctl,
    output logic [AW-1:0]             o_addr
);

    localparam int CW = vbi_pkg::COORD_W;
    localparam int OW = vbi_pkg::OFS_W;

    logic          r_active;
    logic [OW-1:0] r_dx;
    logic [OW-1:0] r_dy;

    logic [vbi_pkg::STEP_W-1:0] span;
    logic [OW-1:0]              span_w;
    logic [OW-1:0]              span_neg;
    logic                       at_dy_end;
    logic                       at_dx_end;
    logic [CW-1:0]              col_x;
    logic [CW-1:0]              col_y;
    logic                       col_ok;
    logic [OW-1:0]              adx;
    logic [OW-1:0]              ady;

    // Pick the larger half-width; the user must change the steps only while idle, the block does not enforce it
    assign span     = (i_inflate_steps > i_extra_steps) ? i_inflate_steps : i_extra_steps;
    assign span_w   = {1'b0, span};
    assign span_neg = {OW{1'b0}} - span_w;
    assign at_dy_end = (r_dy == span_w);
    assign at_dx_end = (r_dx == span_w);

    // Advance the offsets: y fastest, then x
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_dx     <= span_neg;
            r_dy     <= span_neg;
        end else if (r_active) begin
            if (at_dy_end) begin
                r_dy <= span_neg;
                if (at_dx_end) begin
                    r_active <= 1'b0;
                end else begin
                    r_dx <= r_dx + 1'b1;
                end
            end else begin
                r_dy <= r_dy + 1'b1;
            end
        end
    end

    // Column coordinates and grid check
    assign col_x  = CW'(i_cx) + {{(CW-OW){r_dx[OW-1]}}, r_dx};
    assign col_y  = CW'(i_cy) + {{(CW-OW){r_dy[OW-1]}}, r_dy};
    assign col_ok = !col_x[CW-1] && (col_x < CW'(GRID_X))
                 && !col_y[CW-1] && (col_y < CW'(GRID_Y));

    // Per-map box membership
    assign adx = r_dx[OW-1] ? ({OW{1'b0}} - r_dx) : r_dx;
    assign ady = r_dy[OW-1] ? ({OW{1'b0}} - r_dy) : r_dy;

    always_comb begin
        o_ctl.active  = r_active;
        o_ctl.in_grid = r_active && col_ok;
        o_ctl.last    = r_active && at_dx_end && at_dy_end;
        o_ctl.set_inf = (adx <= {1'b0, i_inflate_steps}) && (ady <= {1'b0, i_inflate_steps});
        o_ctl.set_ext = (adx <= {1'b0, i_extra_steps}) && (ady <= {1'b0, i_extra_steps});
    end

    assign o_addr = AW'(col_x[XW-1:0]) * AW'(GRID_Y) + AW'(col_y[YW-1:0]);

endmodule

/* hw/rtl/vbi_checker.sv */
module vbi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_kind,
    input logic       o_result_valid,
    input logic       o_in_grid,
    input logic       o_inflated_bit,
    input logic       o_extra_bit,
    input logic       o_map_done,
    input logic       o_mark_taken
);

    // An end item answers at once with the map frozen
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == vbi_pkg::KIND_END)
            |=> (o_result_valid && o_map_done && !o_mark_taken))
        else $error("end item did not give a done result next cycle");

    // An applied mark lies in the grid and the map is still open
    a_mark_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_mark_taken) |-> (o_in_grid && !o_map_done))
        else $error("mark applied outside grid or after completion");

    // Map bits only come back for an in-grid voxel
    a_bits_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_inflated_bit || o_extra_bit)) |-> o_in_grid)
        else $error("map bit reported for an out-of-grid voxel");

    // A clear item runs the clearing pass
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == vbi_pkg::KIND_CLEAR) |=> (busy && !o_result_valid))
        else $error("clear item did not start the clearing pass");

endmodule

bind voxel_box_inflation vbi_checker u_vbi_checker (.*);

/* tb/sv/voxel_box_inflation_test.sv */
module voxel_box_inflation_test;

    localparam int GX = vbi_pkg::DEF_GRID_X;
    localparam int GY = vbi_pkg::DEF_GRID_Y;
    localparam int GZ = vbi_pkg::DEF_GRID_Z;
    localparam int ITEM_GOAL = 1000;
    // no idle bursts once this many items went in
    localparam int CALM_FROM = 850;

    typedef logic signed [vbi_pkg::VOX_W-1:0] t_vox;

    typedef struct packed {
        logic in_grid;
        logic inflated_bit;
        logic extra_bit;
        logic map_done;
        logic mark_taken;
    } t_outcome;

    // Shadow copy of both maps; predicts one outcome per item and checks it
    class inflation_tracker;
        bit [GZ-1:0] inflate_col [GX*GY];
        bit [GZ-1:0] extra_col [GX*GY];
        bit done_flag;
        bit [vbi_pkg::STEP_W-1:0] inflate_steps;
        bit [vbi_pkg::STEP_W-1:0] extra_steps;
        t_outcome pending[$];
        int mismatch_count;

        function new();
            inflate_steps = vbi_pkg::INFLATE_RST;
            extra_steps = vbi_pkg::EXTRA_RST;
        endfunction

        function void set_steps(bit [vbi_pkg::STEP_W-1:0] inf,
                                bit [vbi_pkg::STEP_W-1:0] ext);
            inflate_steps = inf;
            extra_steps = ext;
        endfunction

        function void note_item(vbi_pkg::t_kind kind, t_vox vx, t_vox vy, t_vox vz);
            int x, y, z, c, k, dx, dy, reach, ax, ay;
            bit [GZ-1:0] zbits;
            t_outcome r;
            x = vx;
            y = vy;
            z = vz;
            r = '0;
            r.in_grid = x >= 0 && x < GX && y >= 0 && y < GY && z >= 0 && z < GZ;
            case (kind)
                vbi_pkg::KIND_MARK: begin
                    if (!done_flag && r.in_grid) begin
                        zbits = '0;
                        for (k = z - 1; k <= z + 1; k++)
                            if (k >= 0 && k < GZ) zbits[k] = 1'b1;
                        reach = (inflate_steps > extra_steps) ? inflate_steps : extra_steps;
                        // paint both boxes, skipping columns off the grid
                        for (dx = -reach; dx <= reach; dx++) begin
                            if (x + dx < 0 || x + dx >= GX) continue;
                            for (dy = -reach; dy <= reach; dy++) begin
                                if (y + dy < 0 || y + dy >= GY) continue;
                                c = (x + dx) * GY + (y + dy);
                                ax = (dx < 0) ? -dx : dx;
                                ay = (dy < 0) ? -dy : dy;
                                if (ax <= inflate_steps && ay <= inflate_steps)
                                    inflate_col[c] |= zbits;
                                if (ax <= extra_steps && ay <= extra_steps)
                                    extra_col[c] |= zbits;
                            end
                        end
                        r.mark_taken = 1'b1;
                    end
                end
                vbi_pkg::KIND_END: done_flag = 1'b1;
                vbi_pkg::KIND_QUERY: begin
                    if (r.in_grid) begin
                        c = x * GY + y;
                        r.inflated_bit = inflate_col[c][z];
                        r.extra_bit = extra_col[c][z];
                    end
                end
                default: begin
                    foreach (inflate_col[i]) begin
                        inflate_col[i] = '0;
                        extra_col[i] = '0;
                    end
                    done_flag = 1'b0;
                end
            endcase
            r.map_done = done_flag;
            pending = {pending, r};
        endfunction

        function void compare(string name, logic want, logic got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                $error("result strobe with no item outstanding");
                mismatch_count++;
                return;
            end
            want = pending.pop_front();
            compare("in_grid", want.in_grid, got.in_grid);
            compare("inflated_bit", want.inflated_bit, got.inflated_bit);
            compare("extra_bit", want.extra_bit, got.extra_bit);
            compare("map_done", want.map_done, got.map_done);
            compare("mark_taken", want.mark_taken, got.mark_taken);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [1:0] i_kind;
    t_vox i_vox_x;
    t_vox i_vox_y;
    t_vox i_vox_z;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [vbi_pkg::STEP_W-1:0] i_cfg_data;
    logic o_result_valid;
    logic o_in_grid;
    logic o_inflated_bit;
    logic o_extra_bit;
    logic o_map_done;
    logic o_mark_taken;

    inflation_tracker board;
    int items_sent;
    bit calm;

    voxel_box_inflation uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_vox_x        (i_vox_x),
        .i_vox_y        (i_vox_y),
        .i_vox_z        (i_vox_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_in_grid      (o_in_grid),
        .o_inflated_bit (o_inflated_bit),
        .o_extra_bit    (o_extra_bit),
        .o_map_done     (o_map_done),
        .o_mark_taken   (o_mark_taken)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard limit on the simulation time
    initial begin
        #(64'd24_000_000);
        $display("Mismatches found");
        $finish;
    end

    // Check each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1)
            board.check_result(t_outcome'({o_in_grid, o_inflated_bit, o_extra_bit,
                                           o_map_done, o_mark_taken}));
    end

    function automatic t_vox rnd8();
        return t_vox'($urandom);
    endfunction

    // Mostly uniform, sometimes pinned to the first or last index
    function automatic int grid_pick(int n);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return n - 1;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    // Present one item and hold it until taken; leave start high unless idling
    task automatic send_item(vbi_pkg::t_kind kind, t_vox x, t_vox y, t_vox z);
        i_kind <= kind;
        i_vox_x <= x;
        i_vox_y <= y;
        i_vox_z <= z;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_item(kind, x, y, z);
        items_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every outstanding item has its result
    task automatic drain_items();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_steps(bit [vbi_pkg::STEP_W-1:0] inf,
                               bit [vbi_pkg::STEP_W-1:0] ext);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= vbi_pkg::REG_INFLATE;
        i_cfg_data <= inf;
        @(posedge i_clk);
        i_cfg_idx <= vbi_pkg::REG_EXTRA;
        i_cfg_data <= ext;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_steps(inf, ext);
    endtask

    task automatic noise_item();
        send_item(vbi_pkg::t_kind'($urandom_range(0, 3)), rnd8(), rnd8(), rnd8());
    endtask

    // Query a voxel close to one of the marks, up to just past the box borders; with no marks, a random grid voxel
    task automatic query_near(ref int mx[$], ref int my[$], ref int mz[$]);
        int j, span, qx, qy, qz;
        span = ((board.inflate_steps > board.extra_steps) ?
                board.inflate_steps : board.extra_steps) + 1;
        if (mx.size() == 0) begin
            send_item(vbi_pkg::KIND_QUERY, t_vox'(grid_pick(GX)), t_vox'(grid_pick(GY)),
                      t_vox'(grid_pick(GZ)));
        end else begin
            j = $urandom_range(0, mx.size() - 1);
            qx = mx[j] + int'($urandom_range(0, 2 * span)) - span;
            qy = my[j] + int'($urandom_range(0, 2 * span)) - span;
            qz = mz[j] + int'($urandom_range(0, 4)) - 2;
            send_item(vbi_pkg::KIND_QUERY, t_vox'(qx), t_vox'(qy), t_vox'(qz));
        end
    endtask

    // One cloud: clear, marks with queries between, end, then mostly queries
    task automatic run_cloud();
        int mx[$], my[$], mz[$];
        int n, x, y, z;
        send_item(vbi_pkg::KIND_CLEAR, rnd8(), rnd8(), rnd8());
        n = $urandom_range(1, 7);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                noise_item();
            end else begin
                x = grid_pick(GX);
                y = grid_pick(GY);
                z = grid_pick(GZ);
                mx = {mx, x};
                my = {my, y};
                mz = {mz, z};
                send_item(vbi_pkg::KIND_MARK, t_vox'(x), t_vox'(y), t_vox'(z));
            end
            if ($urandom_range(0, 3) == 0) query_near(mx, my, mz);
        end
        send_item(vbi_pkg::KIND_END, rnd8(), rnd8(), rnd8());
        repeat ($urandom_range(10, 25)) begin
            case ($urandom_range(0, 9))
                0: send_item(vbi_pkg::KIND_MARK, t_vox'(grid_pick(GX)),
                             t_vox'(grid_pick(GY)), t_vox'(grid_pick(GZ)));
                1: noise_item();
                default: query_near(mx, my, mz);
            endcase
        end
    endtask

    initial begin
        int phase;
        bit [vbi_pkg::STEP_W-1:0] inf, ext;
        board = new();
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_kind <= vbi_pkg::KIND_MARK;
        i_vox_x <= '0;
        i_vox_y <= '0;
        i_vox_z <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= vbi_pkg::REG_INFLATE;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset box sizes
        send_item(vbi_pkg::KIND_QUERY, 0, 0, 0);
        send_item(vbi_pkg::KIND_MARK, 0, 0, 0);
        send_item(vbi_pkg::KIND_MARK, 63, 63, 31);
        send_item(vbi_pkg::KIND_MARK, -128, 5, 5);
        send_item(vbi_pkg::KIND_MARK, 64, 5, 5);
        send_item(vbi_pkg::KIND_MARK, 5, -1, 5);
        send_item(vbi_pkg::KIND_MARK, 5, 5, 32);
        send_item(vbi_pkg::KIND_QUERY, 2, 2, 1);
        send_item(vbi_pkg::KIND_QUERY, 3, 0, 0);
        send_item(vbi_pkg::KIND_QUERY, 0, 0, 2);
        send_item(vbi_pkg::KIND_QUERY, 63, 63, 30);
        send_item(vbi_pkg::KIND_QUERY, 127, 127, 127);
        send_item(vbi_pkg::KIND_QUERY, -1, 0, 0);
        send_item(vbi_pkg::KIND_END, -128, -128, -128);
        send_item(vbi_pkg::KIND_END, 0, 63, 31);
        send_item(vbi_pkg::KIND_MARK, 10, 10, 10);
        send_item(vbi_pkg::KIND_QUERY, 10, 10, 10);
        send_item(vbi_pkg::KIND_CLEAR, 5, 5, 5);
        send_item(vbi_pkg::KIND_QUERY, 0, 0, 0);
        send_item(vbi_pkg::KIND_END, 1, 1, 1);
        send_item(vbi_pkg::KIND_CLEAR, 127, -1, 0);
        send_item(vbi_pkg::KIND_MARK, 31, 32, 16);
        send_item(vbi_pkg::KIND_QUERY, 33, 34, 17);
        send_item(vbi_pkg::KIND_QUERY, 31, 36, 16);
        send_item(vbi_pkg::KIND_QUERY, 31, 37, 15);

        // Random part: up to three clouds per box-size setting
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            drain_items();
            case (phase)
                0: begin inf = '0; ext = '0; end
                1: begin inf = '1; ext = '1; end
                2: begin inf = '0; ext = '1; end
                3: begin inf = '1; ext = '0; end
                default: begin
                    inf = vbi_pkg::STEP_W'($urandom_range(0, 7));
                    ext = vbi_pkg::STEP_W'($urandom_range(0, 7));
                end
            endcase
            write_steps(inf, ext);
            phase++;
            repeat (3) begin
                if (items_sent < ITEM_GOAL) run_cloud();
                calm = items_sent >= CALM_FROM;
            end
        end

        drain_items();
        repeat (16) @(posedge i_clk);
        if (board.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
